// ===== hdl/bhs_pkg.sv =====
// Shared types, grid constants and codes for the bilinear height sampler.
package bhs_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
  localparam int COL_BITS = $clog2(GRID_COLS);
  localparam int ROW_BITS = $clog2(GRID_ROWS);
  localparam int IDX_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
  localparam int ADDR_BITS = $clog2(GRID_DEPTH);
  localparam int HEIGHT_BITS = 24;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_INV_EXTENT_X = 2'd2;
  localparam logic [1:0] CFG_INV_EXTENT_Y = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [5:0]         grid_row;
    logic [5:0]         grid_col;
    logic signed [23:0] sample_height;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] height_out;
    logic               clamped;
  } out_item_t;

endpackage

// ===== hdl/bilinear_height_sampler.sv =====
// Top level of the bilinear height sampler: grid store, axis mapping and blend.
// - Input channel (in_valid / in_stall / in_item): an item is taken at a clock edge
//   with in_valid high and in_stall low. A write item (operation = 0) stores one
//   Q16.8 height at grid_row, grid_col; a query item (operation = 1) returns the
//   bilinear blend of the four samples around point_x, point_y.
// - Output channel (out_valid / out_stall / out_item): exactly one result item per
//   input item, in order. Writes return zero. clamped flags a query that fell
//   outside the domain and was pinned to the edge cell.
// - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; write only while no item is in flight.
// Timing
// - One item at a time through a sequencer around a single-port grid RAM.
//   A write goes from accept straight to the output step; a query runs two passes
//   of a shared 32x32 multiplier, a map step, four RAM reads on the single port,
//   four blend steps and the output step. The next item is taken in the cycle
//   after the result is registered.
// - A result waits in the output register while out_stall is high; the sequencer
//   can take and process the next item meanwhile and holds it at the output step.
// - Reset clears the sequencer, output valid and config registers. The grid is
//   not cleared: entries hold nothing defined until written.
module bilinear_height_sampler (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bhs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bhs_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import bhs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MULX, S_MULY, S_MAP, S_READ, S_TOP, S_BOT, S_ACC1, S_ACC2, S_OUT
  } state_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] pos;
    logic [16:0]         frac;
    logic                clamp;
  } axis_t;

  // Clamp the normalized coordinate, scale it by (cells - 1), split cell/fraction.
  // The far edge lands on the last cell with a full fraction.
  function automatic axis_t map_axis(input logic neg, input logic [31:0] u,
                                     input int cells);
    logic [16:0]          u16;
    logic [IDX_BITS+16:0] s;
    logic [IDX_BITS:0]    idx;
    axis_t                a;
    a.clamp = neg || (u > 32'd65536);
    if (neg) begin
      u16 = 17'd0;
    end else if (u > 32'd65536) begin
      u16 = 17'h10000;
    end else begin
      u16 = u[16:0];
    end
    s   = (IDX_BITS+17)'(u16) * (IDX_BITS+17)'(cells - 1);
    idx = s[IDX_BITS+16:16];
    if (int'(idx) >= cells - 1) begin
      a.pos  = IDX_BITS'(cells - 2);
      a.frac = 17'h10000;
    end else begin
      a.pos  = idx[IDX_BITS-1:0];
      a.frac = {1'b0, s[15:0]};
    end
    return a;
  endfunction

  state_t state;

  // config registers
  logic signed [31:0] origin_x, origin_y;
  logic [31:0]        inv_extent_x, inv_extent_y;

  // datapath
  logic signed [32:0] dx, dy;
  logic [31:0]        ux, uy;
  axis_t              ax, ay;
  logic               is_query;
  logic signed [23:0] v [4];
  logic signed [41:0] top, bot;
  logic signed [59:0] acc;
  logic [1:0]         rd_cnt, rd_sel;
  logic               rd_pend;

  logic               in_acc, ram_we;
  logic [ADDR_BITS-1:0] wr_addr, rd_addr, ram_addr;
  logic [HEIGHT_BITS-1:0] ram_q;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic signed [17:0] wx0, wx1, wy0, wy1;
  logic signed [59:0] rounded;
  logic               out_load;
  logic [IDX_BITS:0]  rr, cc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  // Writes go straight to the RAM in the accept cycle; reads come later, so a
  // query never overlaps a pending write.
  assign ram_we  = in_acc && (in_item.operation == OP_WRITE) &&
                   (int'(in_item.grid_row) < GRID_ROWS) &&
                   (int'(in_item.grid_col) < GRID_COLS);
  assign wr_addr = ADDR_BITS'(int'(in_item.grid_row) * GRID_COLS + int'(in_item.grid_col));
  assign rr      = {1'b0, ay.pos} + (IDX_BITS+1)'(rd_cnt[1]);
  assign cc      = {1'b0, ax.pos} + (IDX_BITS+1)'(rd_cnt[0]);
  assign rd_addr = ADDR_BITS'(int'(rr) * GRID_COLS + int'(cc));
  assign ram_addr = (state == S_IDLE) ? wr_addr : rd_addr;

  bhs_ram #(
    .WIDTH(HEIGHT_BITS),
    .DEPTH(GRID_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_item.sample_height),
    .q    (ram_q)
  );

  // One 32x32 multiplier, x pass then y pass. Negative offsets are forced to zero later.
  assign mul_a = (state == S_MULX) ? dx[31:0] : dy[31:0];
  assign mul_b = (state == S_MULX) ? inv_extent_x : inv_extent_y;
  assign mul_p = mul_a * mul_b;

  assign wx1 = $signed({1'b0, ax.frac});
  assign wx0 = $signed({1'b0, 17'h10000 - ax.frac});
  assign wy1 = $signed({1'b0, ay.frac});
  assign wy0 = $signed({1'b0, 17'h10000 - ay.frac});
  // round half up, then drop the 32 weight bits
  assign rounded = acc + 60'sd2147483648;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      inv_extent_x <= '0;
      inv_extent_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:     origin_x     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y     <= cfg_data;
        CFG_INV_EXTENT_X: inv_extent_x <= cfg_data;
        CFG_INV_EXTENT_Y: inv_extent_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_cnt    <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= (in_item.operation == OP_QUERY) ? S_MULX : S_OUT;
          end
        end
        S_MULX: state <= S_MULY;
        S_MULY: state <= S_MAP;
        S_MAP:  state <= S_READ;
        S_READ: begin
          // read data lands in the cycle after the read is issued; corner 3 is captured during S_TOP
          rd_sel  <= rd_cnt;
          rd_cnt  <= rd_cnt + 2'd1;
          if (rd_cnt == 2'd3) begin
            state <= S_TOP;
          end
        end
        S_TOP:  state <= S_BOT;
        S_BOT:  state <= S_ACC1;
        S_ACC1: state <= S_ACC2;
        S_ACC2: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_item.height_out <= is_query ? rounded[55:32] : '0;
            out_item.clamped    <= is_query && (ax.clamp || ay.clamp);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_query <= (in_item.operation == OP_QUERY);
      dx <= {in_item.point_x[31], in_item.point_x} - {origin_x[31], origin_x};
      dy <= {in_item.point_y[31], in_item.point_y} - {origin_y[31], origin_y};
    end
    if (state == S_MULX) begin
      ux <= mul_p[63:32];
    end
    if (state == S_MULY) begin
      uy <= mul_p[63:32];
    end
    if (state == S_MAP) begin
      ax <= map_axis(dx[32], ux, GRID_COLS);
      ay <= map_axis(dy[32], uy, GRID_ROWS);
    end
    if (rd_pend) begin
      v[rd_sel] <= ram_q;
    end
    if (state == S_TOP) begin
      top <= v[0] * wx0 + v[1] * wx1;
    end
    if (state == S_BOT) begin
      bot <= v[2] * wx0 + v[3] * wx1;
    end
    if (state == S_ACC1) begin
      acc <= top * wy0;
    end
    if (state == S_ACC2) begin
      acc <= acc + bot * wy1;
    end
  end

`ifndef SYNTH
  a_write_to_out: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.operation == OP_WRITE) |=> (state == S_OUT))
    else $error("write item did not go straight to the output step");

  a_rd_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_READ) |-> (rd_cnt == 2'd0))
    else $error("corner counter left nonzero outside the read phase");

  a_rd_pend_src: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == S_READ))
    else $error("RAM capture without a read issued");

  a_no_ram_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("grid write outside the idle state");
`endif

endmodule

// ===== hdl/bhs_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module bhs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    q <= mem[addr];
  end

endmodule

// ===== verif/bhs_checker.sv =====
// Predicts each result item of the bilinear height sampler and compares it with the output.
`timescale 1ns / 100ps

module bhs_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bhs_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bhs_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import bhs_pkg::*;

  logic signed [31:0] org_x, org_y;
  logic [31:0]        rcp_x, rcp_y;
  logic signed [23:0] grid_copy [GRID_DEPTH];
  out_item_t          expected_results [$];

  // One axis: point to cell index and Q.16 fraction; flags a clamp.
  function automatic void locate_axis(input logic signed [31:0] p, input logic signed [31:0] org,
                                      input logic [31:0] rcp, input int cells,
                                      output int pos, output longint frac, output logic clip);
    longint q;
    longint unsigned uq, u16, s, idx;
    clip = 1'b0;
    q = longint'(p) - longint'(org);
    if (q < 0) begin
      u16 = 0;
      clip = 1'b1;
    end else begin
      uq = q;
      u16 = (uq * rcp[31:16] + ((uq * rcp[15:0]) >> 16)) >> 16;
      if (u16 > 65536) begin
        u16 = 65536;
        clip = 1'b1;
      end
    end
    s = u16 * longint'(cells - 1);
    idx = s >> 16;
    if (idx >= longint'(cells - 1)) begin
      pos = cells - 2;
      frac = 65536;
    end else begin
      pos = int'(idx);
      frac = longint'(s & 64'hFFFF);
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int        cx, cy, base;
    longint    fx, fy, a00, a01, a10, a11, top, bot, acc;
    logic      kx, ky;
    r = '0;
    if (it.operation == OP_QUERY) begin
      locate_axis(it.point_x, org_x, rcp_x, GRID_COLS, cx, fx, kx);
      locate_axis(it.point_y, org_y, rcp_y, GRID_ROWS, cy, fy, ky);
      base = cy * GRID_COLS + cx;
      a00 = grid_copy[base];
      a01 = grid_copy[base + 1];
      a10 = grid_copy[base + GRID_COLS];
      a11 = grid_copy[base + GRID_COLS + 1];
      top = a00 * (65536 - fx) + a01 * fx;
      bot = a10 * (65536 - fx) + a11 * fx;
      acc = top * (65536 - fy) + bot * fy;
      acc = (acc + 64'sd2147483648) >>> 32;
      r.height_out = acc[23:0];
      r.clamped = kx | ky;
    end
    return r;
  endfunction

  task automatic log_mismatch(input string what, input out_item_t want, input out_item_t got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch (%s): expected height %0d clamped %0b, got height %0d clamped %0b",
               $realtime, what, want.height_out, want.clamped, got.height_out, got.clamped);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      org_x = '0;
      org_y = '0;
      rcp_x = '0;
      rcp_y = '0;
      errors = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          log_mismatch("no item pending", '0, out_item);
        end else begin
          want = expected_results.pop_front();
          if (want.height_out !== out_item.height_out || want.clamped !== out_item.clamped)
            log_mismatch("field", want, out_item);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X:     org_x = cfg_data;
          CFG_ORIGIN_Y:     org_y = cfg_data;
          CFG_INV_EXTENT_X: rcp_x = cfg_data;
          CFG_INV_EXTENT_Y: rcp_y = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_item));
        if (in_item.operation == OP_WRITE)
          grid_copy[in_item.grid_row * GRID_COLS + in_item.grid_col] = in_item.sample_height;
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/bilinear_height_sampler_tb.sv =====
// Stimulus and verdict for the bilinear height sampler, checked by bhs_checker.
`timescale 1ns / 100ps

module bilinear_height_sampler_tb;
  import bhs_pkg::*;

  // A limit well above what roughly 700 items need, with gaps and stalls.
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [23:0] H_MAX = 24'h7FFFFF;
  localparam logic [23:0] H_MIN = 24'h800000;
  localparam int RAND_PHASES = 6;
  localparam int ITEM_TARGET = 650;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  int  errors;
  int  pending;
  int  cycle_count;
  // items sent so far, and where the current random phase stops
  int  sent;
  int  phase_end;
  // grid entries written so far; a query only goes out once its corners are set
  bit  written [GRID_DEPTH];
  // calm: a stretch with neither sender gaps nor receiver stalls
  logic calm;
  // current register settings, kept for shaping query points
  logic [31:0] cur_ox, cur_oy, cur_ix, cur_iy;

  always #5 clk = ~clk;

  bilinear_height_sampler dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bhs_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // Receiver side: random stalls, drawn at about 28 percent, none while calm.
  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 28);
  end

  // Fields a write ignores get random content so every bit toggles.
  function automatic in_item_t mk_write(input logic [5:0] row, input logic [5:0] col,
                                        input logic [23:0] h);
    in_item_t it;
    it.operation     = OP_WRITE;
    it.grid_row      = row;
    it.grid_col      = col;
    it.sample_height = h;
    it.point_x       = $urandom();
    it.point_y       = $urandom();
    return it;
  endfunction

  function automatic in_item_t mk_query(input logic [31:0] x, input logic [31:0] y);
    in_item_t it;
    it.operation     = OP_QUERY;
    it.grid_row      = 6'($urandom());
    it.grid_col      = 6'($urandom());
    it.sample_height = 24'($urandom());
    it.point_x       = x;
    it.point_y       = y;
    return it;
  endfunction

  // A point around the configured domain: span is the domain width in raw Q16.16 units,
  // the draw runs an eighth past each side so edges and clamps come up often.
  function automatic logic [31:0] near_point(input logic [31:0] org, input logic [31:0] rcp);
    longint unsigned span, r;
    span = (rcp == 0) ? 64'h1_0000_0000 : (64'h1_0000_0000_0000 / rcp);
    if (span > 64'h1_0000_0000)
      span = 64'h1_0000_0000;
    r = {$urandom(), $urandom()};
    return org + 32'(r % (span + span / 4 + 1) - span / 8);
  endfunction

  // Cell index a query point lands on along one axis under the given settings.
  function automatic int axis_pos(input logic [31:0] p, input logic [31:0] org,
                                  input logic [31:0] rcp, input int cells);
    longint          q;
    longint unsigned uq, u16, s;
    q = longint'($signed(p)) - longint'($signed(org));
    if (q < 0) begin
      u16 = 0;
    end else begin
      uq = q;
      u16 = (uq * rcp) >> 32;
      if (u16 > 65536)
        u16 = 65536;
    end
    s = (u16 * longint'(cells - 1)) >> 16;
    if (s >= longint'(cells - 1))
      return cells - 2;
    return int'(s);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Offers one item at a falling edge, sometimes after a random gap, and waits for it to be taken.
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (it.operation == OP_WRITE)
      written[int'(it.grid_row) * GRID_COLS + int'(it.grid_col)] = 1'b1;
    sent++;
  endtask

  // Writes any corner the query reads that is still unset, then sends the query.
  task automatic send_query(input logic [31:0] x, input logic [31:0] y);
    int cx, cy, a;
    cx = axis_pos(x, cur_ox, cur_ix, GRID_COLS);
    cy = axis_pos(y, cur_oy, cur_iy, GRID_ROWS);
    for (int k = 0; k < 4; k++) begin
      a = (cy + k / 2) * GRID_COLS + cx + k % 2;
      if (!written[a])
        send_item(mk_write(6'(cy + k / 2), 6'(cx + k % 2), 24'($urandom())));
    end
    send_item(mk_query(x, y));
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Registers are only written with the block idle.
  task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] ix, input logic [31:0] iy);
    logic [31:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{ox, oy, ix, iy};
    idx  = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_INV_EXTENT_X, CFG_INV_EXTENT_Y};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      forever begin
        @(posedge clk);
        if (cfg_ready) break;
      end
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_ox = ox;
    cur_oy = oy;
    cur_ix = ix;
    cur_iy = iy;
  endtask

  // Cycle counter: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bilinear_height_sampler_tb: FAIL");
    $finish;
  end

  initial begin
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_data  = '0;
    calm      = 1'b0;
    sent      = 0;
    phase_end = 0;
    cur_ox    = '0;
    cur_oy    = '0;
    cur_ix    = '0;
    cur_iy    = '0;
    rst       = 1'b1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero reciprocal pins both axes to the grid edge.
    send_query(32'h0000_0000, 32'h0000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // negative x lies below the domain and clamps
    send_query(32'h8000_0000, 32'h7FFF_FFFF);

    // A 64-unit square domain at the origin.
    set_config(32'h0, 32'h0, 32'h0400_0000, 32'h0400_0000);
    // height extremes on the corner cells at both ends of the grid
    send_item(mk_write(6'd0, 6'd0, H_MAX));
    send_item(mk_write(6'd0, 6'd1, H_MIN));
    send_item(mk_write(6'd1, 6'd0, H_MIN));
    send_item(mk_write(6'd1, 6'd1, H_MAX));
    send_item(mk_write(6'd62, 6'd62, H_MAX));
    send_item(mk_write(6'd62, 6'd63, H_MIN));
    send_item(mk_write(6'd63, 6'd62, H_MIN));
    send_item(mk_write(6'd63, 6'd63, H_MAX));
    send_query(32'h0000_0000, 32'h0000_0000);
    send_query(32'h0000_8000, 32'h0000_C000);
    send_query(32'h003F_8000, 32'h003F_C000);
    // exactly on the far edge: full weight on the last cell
    send_query(32'h0040_0000, 32'h0040_0000);
    // just past the far edge in x, just below the domain in y
    send_query(32'h0040_0400, 32'h0000_8000);
    send_query(32'h0000_8000, 32'hFFFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);

    // Register extremes: widest difference, largest and zero reciprocal.
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000);
    send_query(32'h8001_0000, 32'h7FFF_FFFF);

    // Random phases, each under its own settings; one phase runs calm.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(2))
        0: set_config($urandom(), $urandom(),
                      (32'h1 << $urandom_range(31, 16)) | ($urandom() & 32'hFFFF),
                      (32'h1 << $urandom_range(31, 16)) | ($urandom() & 32'hFFFF));
        1: set_config(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        default: set_config($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      calm = (ph == 2);
      phase_end = sent + (ITEM_TARGET - sent) / (RAND_PHASES - ph);
      while (sent < phase_end) begin
        if ($urandom_range(99) < 35)
          send_item(mk_write(6'($urandom()), 6'($urandom()), 24'($urandom())));
        else if ($urandom_range(3) == 0)
          send_query($urandom(), $urandom());
        else
          send_query(near_point(cur_ox, cur_ix), near_point(cur_oy, cur_iy));
      end
      calm = 1'b0;
    end

    drain();
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("bilinear_height_sampler_tb: PASS");
    else
      $display("bilinear_height_sampler_tb: FAIL");
    $finish;
  end

endmodule
